// ----- rtl/prld_pkg.sv -----
// Shared types and constants of the PackBits-style run-length decoder.
package prld_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned GROUP_BYTES = 4;
    localparam int unsigned DATA_W      = 8 * GROUP_BYTES;

    localparam logic [7:0] COUNT_MASK  = 8'h7F;
    localparam logic [7:0] REPEAT_FLAG = 8'h80;

    typedef logic [2:0] t_status;

    localparam t_status ST_OK           = 3'd0;
    localparam t_status ST_RUN_TOO_LONG = 3'd1;
    localparam t_status ST_TRUNCATED    = 3'd2;
    localparam t_status ST_TRAILING     = 3'd3;
    localparam t_status ST_TOO_SHORT    = 3'd4;

    typedef struct packed {
        logic [7:0] value;
        logic [7:0] count;
        logic       last;
        t_status    status;
    } t_cmd;

endpackage

// ----- rtl/prld_in_if.sv -----
// Handshake channel that carries compressed stream bytes.
interface prld_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_final;

    modport source (output valid, output in_byte, output in_final, input ready);
    modport sink (input valid, input in_byte, input in_final, output ready);
endinterface

// ----- rtl/prld_out_if.sv -----
// Handshake channel that carries groups of decoded bytes and the stream status.
interface prld_out_if;
    logic                        valid;
    logic                        ready;
    logic [prld_pkg::DATA_W-1:0] out_data;
    logic [2:0]                  out_valid_bytes;
    logic                        out_end;
    logic [2:0]                  out_status;

    modport source (output valid, output out_data, output out_valid_bytes,
                    output out_end, output out_status, input ready);
    modport sink (input valid, input out_data, input out_valid_bytes,
                  input out_end, input out_status, output ready);
endinterface

// ----- rtl/prld_front.sv -----
// Front end: parses header, repeat and literal bytes and issues expansion commands.
module prld_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [31:0]        i_expected_size,
    prld_in_if.sink            i_in,
    input  logic               i_full,
    output logic               o_push,
    output prld_pkg::t_cmd     o_cmd
);

    typedef enum logic [1:0] {
        MODE_HEADER,
        MODE_REPEAT,
        MODE_LITERAL,
        MODE_DROP
    } t_mode;

    t_mode             r_mode, n_mode;
    logic [7:0]        r_left, n_left;
    logic [31:0]       r_cnt, n_cnt;
    prld_pkg::t_status r_err, n_err;

    logic              accept;
    logic [7:0]        hdr_count;
    logic [32:0]       run_end;
    logic [7:0]        add;
    prld_pkg::t_status end_status;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;
    assign hdr_count  = (i_in.in_byte & prld_pkg::COUNT_MASK) + 8'd1;
    assign run_end    = {1'b0, r_cnt} + {25'd0, hdr_count};

    always_comb begin
        n_mode     = r_mode;
        n_left     = r_left;
        n_err      = r_err;
        n_cnt      = r_cnt;
        add        = 8'd0;
        end_status = prld_pkg::ST_OK;
        if (accept) begin
            unique case (r_mode)
                MODE_HEADER: begin
                    if (r_cnt >= i_expected_size) begin
                        n_err  = prld_pkg::ST_TRAILING;
                        n_mode = MODE_DROP;
                        n_left = 8'd0;
                    end else if (run_end > {1'b0, i_expected_size}) begin
                        n_err  = prld_pkg::ST_RUN_TOO_LONG;
                        n_mode = MODE_DROP;
                        n_left = 8'd0;
                    end else begin
                        n_left = hdr_count;
                        n_mode = ((i_in.in_byte & prld_pkg::REPEAT_FLAG) != 8'd0) ?
                                 MODE_REPEAT : MODE_LITERAL;
                    end
                end
                MODE_REPEAT: begin
                    add    = r_left;
                    n_left = 8'd0;
                    n_mode = MODE_HEADER;
                end
                MODE_LITERAL: begin
                    add = 8'd1;
                    if (r_left != 8'd0) begin
                        n_left = r_left - 8'd1;
                    end
                    if (n_left == 8'd0) begin
                        n_mode = MODE_HEADER;
                    end
                end
                MODE_DROP: begin
                end
                default: begin
                end
            endcase
            n_cnt = r_cnt + {24'd0, add};
            if (i_in.in_final) begin
                if (n_err != prld_pkg::ST_OK) begin
                    end_status = n_err;
                end else if (n_mode == MODE_REPEAT || n_mode == MODE_LITERAL) begin
                    end_status = prld_pkg::ST_TRUNCATED;
                end else if (n_cnt == i_expected_size) begin
                    end_status = prld_pkg::ST_OK;
                end else begin
                    end_status = prld_pkg::ST_TOO_SHORT;
                end
                n_mode = MODE_HEADER;
                n_left = 8'd0;
                n_cnt  = 32'd0;
                n_err  = prld_pkg::ST_OK;
            end
        end
    end

    assign o_push       = accept && (add != 8'd0 || i_in.in_final);
    assign o_cmd.value  = i_in.in_byte;
    assign o_cmd.count  = add;
    assign o_cmd.last   = i_in.in_final;
    assign o_cmd.status = end_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_HEADER;
            r_left <= 8'd0;
            r_cnt  <= 32'd0;
            r_err  <= prld_pkg::ST_OK;
        end else begin
            r_mode <= n_mode;
            r_left <= n_left;
            r_cnt  <= n_cnt;
            r_err  <= n_err;
        end
    end

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.in_final |=> r_cnt == 32'd0 && r_mode == MODE_HEADER &&
                                    r_err == prld_pkg::ST_OK)
        else $error("stream state not cleared after the final item");

    a_push_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && !o_cmd.last |-> o_cmd.count != 8'd0)
        else $error("empty command pushed without end of stream");

endmodule

// ----- rtl/prld_queue.sv -----
// Small command queue between the parsing front end and the expansion back end.
module prld_queue #(
    parameter int unsigned DEPTH = prld_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  prld_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_head_valid,
    output prld_pkg::t_cmd o_head
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    prld_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;

    assign o_full       = (r_count == CW'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("push into a full command queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("pop from an empty command queue");

endmodule

// ----- rtl/prld_back.sv -----
// Back end: expands commands into groups of decoded bytes in an output register.
module prld_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head_valid,
    input  prld_pkg::t_cmd i_head,
    output logic           o_pop,
    prld_out_if.source     o_out
);

    logic [7:0]                  r_offset;
    logic                        r_out_valid;
    logic [prld_pkg::DATA_W-1:0] r_out_data;
    logic [2:0]                  r_out_bytes;
    logic                        r_out_end;
    prld_pkg::t_status           r_out_status;

    logic                        take;
    logic [7:0]                  rem;
    logic                        last_group;
    logic [2:0]                  nbytes;
    logic [prld_pkg::DATA_W-1:0] group_data;

    assign take       = !r_out_valid || o_out.ready;
    assign rem        = i_head.count - r_offset;
    assign last_group = (rem <= 8'(prld_pkg::GROUP_BYTES));
    assign nbytes     = last_group ? rem[2:0] : 3'(prld_pkg::GROUP_BYTES);
    assign o_pop      = i_head_valid && take && last_group;

    always_comb begin
        for (int j = 0; j < prld_pkg::GROUP_BYTES; j++) begin
            group_data[8*j +: 8] = (3'(j) < nbytes) ? i_head.value : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_offset    <= 8'd0;
        end else if (take) begin
            r_out_valid <= i_head_valid;
            if (i_head_valid) begin
                r_offset <= last_group ? 8'd0 : r_offset + 8'(prld_pkg::GROUP_BYTES);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_head_valid) begin
            r_out_data   <= group_data;
            r_out_bytes  <= nbytes;
            r_out_end    <= i_head.last && last_group;
            r_out_status <= (i_head.last && last_group) ? i_head.status : prld_pkg::ST_OK;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.out_data        = r_out_data;
    assign o_out.out_valid_bytes = r_out_bytes;
    assign o_out.out_end         = r_out_end;
    assign o_out.out_status      = r_out_status;

    a_status_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_end |-> r_out_status == prld_pkg::ST_OK)
        else $error("status reported on a result that does not end the stream");

    a_offset_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> r_offset < i_head.count || r_offset == 8'd0)
        else $error("expansion offset beyond the command length");

endmodule

// ----- rtl/packbits_run_length_decoder_core.sv -----
// Top level of the PackBits-style run-length decoder: size register, front end, queue, back end.
//
//   Channel   Dir   Handshake          Content
//   i_in      in    valid/ready        in_byte, in_final
//   o_out     out   valid/ready        out_data, out_valid_bytes, out_end, out_status
//   cfg       in    i_cfg_we           i_cfg_wdata (expected decoded size)
//
// The front end accepts a header, repeat or literal byte every cycle while the command queue
// has room.
// A repeat of N bytes is expanded by the back end into ceil(N/4) groups of up to four bytes,
// so long runs fill the queue and then hold off the input.
// Reset is synchronous and active low; it clears the size register, the parser, the queue and the output valid flag.
// The output register holds its result while o_out.ready is low and the front end keeps working.
module packbits_run_length_decoder_core #(
    parameter int unsigned QUEUE_DEPTH = prld_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    prld_in_if.sink     i_in,
    prld_out_if.source  o_out
);

    logic [31:0]    r_expected_size;
    logic           push;
    logic           full;
    logic           pop;
    logic           head_valid;
    prld_pkg::t_cmd cmd;
    prld_pkg::t_cmd head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_size <= 32'd0;
        end else if (i_cfg_we) begin
            r_expected_size <= i_cfg_wdata;
        end
    end

    prld_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_expected_size (r_expected_size),
        .i_in            (i_in),
        .i_full          (full),
        .o_push          (push),
        .o_cmd           (cmd)
    );

    prld_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (cmd),
        .o_full       (full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    prld_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the PackBits-style run-length decoder core.
module testbench;

    localparam int unsigned LIMIT_CYCLES  = 1000000;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned RANDOM_ITEMS  = 140;
    localparam int          GB            = int'(prld_pkg::GROUP_BYTES);

    typedef enum logic [1:0] {PM_HEADER, PM_REPEAT, PM_LITERAL, PM_DROP} t_parse;
    typedef enum int {SK_GOOD, SK_SHORT, SK_CUT, SK_EXTRA, SK_OVERRUN, SK_NOISE} t_stream_kind;

    typedef struct {
        logic [prld_pkg::DATA_W-1:0] data;
        logic [2:0]                  nbytes;
        logic                        last;
        prld_pkg::t_status           status;
    } t_group;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [31:0] i_cfg_wdata;

    prld_in_if  in_ch ();
    prld_out_if out_ch ();

    packbits_run_length_decoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    logic [31:0]       size_reg;
    t_parse            parse_mode;
    logic [7:0]        token_left;
    logic [31:0]       produced;
    prld_pkg::t_status first_error;

    t_group      expected_groups[$];
    logic [7:0]  stream_buf[$];
    int          mismatches = 0;
    int          live_items;
    int          cycle_count = 0;
    int          stall_left;
    bit          calm;
    int          hold_asked = 0;
    int          hold_served;

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    initial begin
        out_ch.ready = 1'b0;
        stall_left   = 0;
        hold_served  = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                out_ch.ready <= 1'b0;
            end else if (hold_served != hold_asked) begin
                hold_served = hold_asked;
                stall_left = HOLD_CYCLES - 1;
                out_ch.ready <= 1'b0;
            end else if (calm || $urandom_range(0, 3) != 0) begin
                out_ch.ready <= 1'b1;
            end else begin
                stall_left = pick_gap() - 1;
                out_ch.ready <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_output
        t_group want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_groups.size() == 0) begin
                $error("unexpected result: out_data %h, out_valid_bytes %0d",
                       out_ch.out_data, out_ch.out_valid_bytes);
                mismatches = mismatches + 1;
            end else begin
                want = expected_groups.pop_front();
                if (out_ch.out_data !== want.data) begin
                    $error("out_data: expected %h, got %h", want.data, out_ch.out_data);
                    mismatches = mismatches + 1;
                end
                if (out_ch.out_valid_bytes !== want.nbytes) begin
                    $error("out_valid_bytes: expected %0d, got %0d",
                           want.nbytes, out_ch.out_valid_bytes);
                    mismatches = mismatches + 1;
                end
                if (out_ch.out_end !== want.last) begin
                    $error("out_end: expected %0d, got %0d", want.last, out_ch.out_end);
                    mismatches = mismatches + 1;
                end
                if (out_ch.out_status !== want.status) begin
                    $error("out_status: expected %0d, got %0d", want.status, out_ch.out_status);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    function automatic void clear_stream_state();
        parse_mode  = PM_HEADER;
        token_left  = 8'd0;
        produced    = 32'd0;
        first_error = prld_pkg::ST_OK;
    endfunction

    function automatic void latch_error(input prld_pkg::t_status code);
        first_error = code;
        parse_mode  = PM_DROP;
        token_left  = 8'd0;
    endfunction

    function automatic void queue_group(input t_group grp);
        expected_groups = {expected_groups, grp};
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        stream_buf = {stream_buf, b};
    endfunction

    // Works out the groups that one compressed byte produces and queues them.
    function automatic void predict_groups(input logic [7:0] b, input logic last_byte);
        logic [31:0]       room;
        logic [31:0]       cnt;
        int                nbytes;
        int                ngroups;
        int                n;
        prld_pkg::t_status status;
        t_group            grp;
        nbytes = 0;
        room = (produced < size_reg) ? size_reg - produced : 32'd0;
        case (parse_mode)
            PM_HEADER: begin
                cnt = {24'd0, b & prld_pkg::COUNT_MASK} + 32'd1;
                if (room == 32'd0) begin
                    latch_error(prld_pkg::ST_TRAILING);
                end else if (cnt > room) begin
                    latch_error(prld_pkg::ST_RUN_TOO_LONG);
                end else begin
                    token_left = cnt[7:0];
                    parse_mode = ((b & prld_pkg::REPEAT_FLAG) != 8'd0) ? PM_REPEAT : PM_LITERAL;
                end
            end
            PM_REPEAT: begin
                nbytes     = int'(token_left);
                produced   = produced + 32'(nbytes);
                token_left = 8'd0;
                parse_mode = PM_HEADER;
            end
            PM_LITERAL: begin
                nbytes   = 1;
                produced = produced + 32'd1;
                if (token_left > 8'd0) begin
                    token_left = token_left - 8'd1;
                end
                if (token_left == 8'd0) begin
                    parse_mode = PM_HEADER;
                end
            end
            default: begin
            end
        endcase

        if (first_error != prld_pkg::ST_OK) begin
            status = first_error;
        end else if (parse_mode == PM_REPEAT || parse_mode == PM_LITERAL) begin
            status = prld_pkg::ST_TRUNCATED;
        end else if (produced == size_reg) begin
            status = prld_pkg::ST_OK;
        end else begin
            status = prld_pkg::ST_TOO_SHORT;
        end

        ngroups = (nbytes + GB - 1) / GB;
        for (int k = 0; k < ngroups; k++) begin
            n = nbytes - k * GB;
            if (n > GB) begin
                n = GB;
            end
            grp.data = '0;
            for (int j = 0; j < n; j++) begin
                grp.data[8*j +: 8] = b;
            end
            grp.nbytes = 3'(n);
            grp.last   = last_byte && (k == ngroups - 1);
            grp.status = grp.last ? status : prld_pkg::ST_OK;
            queue_group(grp);
        end
        if (last_byte && ngroups == 0) begin
            grp.data   = '0;
            grp.nbytes = 3'd0;
            grp.last   = 1'b1;
            grp.status = status;
            queue_group(grp);
        end
        if (last_byte) begin
            clear_stream_state();
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last_byte);
        int gap;
        gap = (calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.in_byte  <= b;
        in_ch.in_final <= last_byte;
        do @(posedge i_clk); while (!in_ch.ready);
        live_items = live_items + 1;
        predict_groups(b, last_byte);
    endtask

    task automatic send_stream();
        for (int i = 0; i < stream_buf.size(); i++) begin
            send_byte(stream_buf[i], i == stream_buf.size() - 1);
        end
    endtask

    task automatic wait_decoder_idle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_groups.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        size_reg = value;
    endtask

    task automatic append_tokens(input int amount);
        int left;
        int cnt;
        int cap;
        left = amount;
        while (left > 0) begin
            cap = ($urandom_range(0, 4) == 0) ? 128 : 6;
            cnt = $urandom_range(1, (left < cap) ? left : cap);
            if ($urandom_range(0, 1) == 1) begin
                add_byte(prld_pkg::REPEAT_FLAG | 8'(cnt - 1));
                add_byte(8'($urandom));
            end else begin
                add_byte(8'(cnt - 1));
                repeat (cnt) add_byte(8'($urandom));
            end
            left = left - cnt;
        end
    endtask

    task automatic build_stream(input t_stream_kind kind);
        int gen;
        int part;
        int left;
        int cnt;
        gen = (size_reg > 32'd300) ? 40 : int'(size_reg);
        part = (gen > 0) ? $urandom_range(0, gen - 1) : 0;
        stream_buf.delete();
        case (kind)
            SK_GOOD: append_tokens(gen);
            SK_SHORT: append_tokens(part);
            SK_CUT: begin
                append_tokens(gen);
                if (stream_buf.size() > 1) begin
                    repeat ($urandom_range(1, stream_buf.size() - 1)) begin
                        void'(stream_buf.pop_back());
                    end
                end
            end
            SK_EXTRA: begin
                append_tokens(gen);
                repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
            end
            SK_OVERRUN: begin
                append_tokens(part);
                left = gen - part;
                if (left < 128) begin
                    cnt = $urandom_range(left + 1, 128);
                    add_byte(($urandom_range(0, 1) == 1 ? prld_pkg::REPEAT_FLAG : 8'h00)
                             | 8'(cnt - 1));
                    add_byte(8'($urandom));
                end
            end
            default: begin
                repeat ($urandom_range(1, 10)) add_byte(8'($urandom));
            end
        endcase
        if (stream_buf.size() == 0) begin
            add_byte(8'($urandom));
        end
    endtask

    function automatic logic [31:0] random_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            return 32'd0;
        end else if (r < 12) begin
            return 32'hFFFF_FFFF;
        end else if (r < 16) begin
            return $urandom;
        end else if (r < 22) begin
            return $urandom_range(129, 260);
        end
        return $urandom_range(1, 40);
    endfunction

    function automatic t_stream_kind random_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return SK_GOOD;
        if (r < 63) return SK_SHORT;
        if (r < 71) return SK_CUT;
        if (r < 79) return SK_EXTRA;
        if (r < 89) return SK_OVERRUN;
        return SK_NOISE;
    endfunction

    task automatic test_literal_then_repeat();
        write_size(32'd9);
        send_byte(8'h02, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h85, 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_decoder_idle();
    endtask

    task automatic test_longest_repeat();
        write_size(32'd128);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b1);
        wait_decoder_idle();
    endtask

    task automatic test_trailing_input();
        write_size(32'd0);
        send_byte(8'h00, 1'b1);
        wait_decoder_idle();
        write_size(32'd2);
        send_byte(8'h81, 1'b0);
        send_byte(8'h44, 1'b0);
        send_byte(8'h00, 1'b1);
        wait_decoder_idle();
    endtask

    task automatic test_run_too_long();
        write_size(32'd4);
        send_byte(8'h84, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b1);
        wait_decoder_idle();
    endtask

    task automatic test_truncated_token();
        send_byte(8'h03, 1'b0);
        send_byte(8'hAA, 1'b1);
        send_byte(8'h81, 1'b1);
        wait_decoder_idle();
    endtask

    task automatic test_too_short();
        send_byte(8'h81, 1'b0);
        send_byte(8'h33, 1'b1);
        wait_decoder_idle();
        write_size(32'hFFFF_FFFF);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b1);
        wait_decoder_idle();
    endtask

    // The size is lowered below the length of a run whose header was already accepted, in the middle of a stream.
    task automatic test_size_lowered_mid_stream();
        write_size(32'd8);
        send_byte(8'h83, 1'b0);
        wait_decoder_idle();
        write_size(32'd2);
        send_byte(8'h55, 1'b1);
        wait_decoder_idle();
    endtask

    // The output holds off for a long stretch while long runs keep arriving.
    task automatic test_output_hold_off();
        write_size(32'd1024);
        calm = 1'b1;
        hold_asked = hold_asked + 1;
        for (int i = 0; i < 8; i++) begin
            send_byte(8'hFF, 1'b0);
            send_byte(8'($urandom), i == 7);
        end
        wait_decoder_idle();
        calm = 1'b0;
    endtask

    task automatic test_random_streams();
        bit first;
        first = 1'b1;
        live_items = 0;
        while (live_items < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 3) == 0);
            if (first || $urandom_range(0, 1) == 1) begin
                wait_decoder_idle();
                write_size(random_size());
                first = 1'b0;
            end
            build_stream(random_kind());
            send_stream();
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = 32'd0;
        in_ch.valid    = 1'b0;
        in_ch.in_byte  = 8'd0;
        in_ch.in_final = 1'b0;
        live_items     = 0;
        calm           = 1'b0;
        size_reg       = 32'd0;
        clear_stream_state();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_literal_then_repeat();
        test_longest_repeat();
        test_trailing_input();
        test_run_too_long();
        test_truncated_token();
        test_too_short();
        test_size_lowered_mid_stream();
        test_output_hold_off();
        test_random_streams();

        wait_decoder_idle();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/prld_pkg.sv
rtl/prld_in_if.sv
rtl/prld_out_if.sv
rtl/prld_front.sv
rtl/prld_queue.sv
rtl/prld_back.sv
rtl/packbits_run_length_decoder_core.sv
tb/testbench.sv
